@@ rtl/core/vng_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vng_pkg: shared types and constants of the vertex normal generator
// Item, result and queued command formats, mode codes and widths.
// ----------------------------------------------------------------------------
package vng_pkg;

  localparam int IDX_W             = 10;
  localparam int FIELD_W           = 16;
  localparam int ACC_W             = 48;
  localparam int DEF_VERTEX_COUNT  = 1024;
  localparam int DEF_POSITION_BITS = 16;

  // Mode codes of an input item
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Command kinds after classification
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TRI,
    CMD_READ,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]                mode;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic [IDX_W-1:0]          corner_b_index;
    logic [IDX_W-1:0]          corner_c_index;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
    logic                      degenerate;
    logic                      index_error;
  } result_t;

  // Fixed results: zero-length sum and out-of-range index
  localparam result_t RES_DEGEN = '{normal_x: '0, normal_y: '0, normal_z: '0,
                                    degenerate: 1'b1, index_error: 1'b0};
  localparam result_t RES_INDEX_ERR = '{normal_x: '0, normal_y: '0, normal_z: '0,
                                        degenerate: 1'b0, index_error: 1'b1};

  typedef struct packed {
    cmd_kind_e          kind;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic [IDX_W-1:0]   idx_c;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] pos_z;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/vng_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vng_front: item intake
// Accepts items, checks indexes against the vertex store and classifies
// each item into a command for the queue.
// ----------------------------------------------------------------------------
module vng_front #(
  parameter int VERTEX_COUNT = vng_pkg::DEF_VERTEX_COUNT
) (
  input  logic           start_i,
  output logic           busy_o,
  input  vng_pkg::item_t item_i,
  input  logic           queue_full_i,
  input  logic           clear_busy_i,
  output logic           push_o,
  output vng_pkg::cmd_t  cmd_o
);
  import vng_pkg::*;

  logic a_ok, b_ok, c_ok;

  // Hold off items while the queue is full or the store is being cleared
  assign busy_o = queue_full_i || clear_busy_i;

  // Check indexes
  always_comb begin
    a_ok = 32'(item_i.vertex_index) < VERTEX_COUNT;
    b_ok = 32'(item_i.corner_b_index) < VERTEX_COUNT;
    c_ok = 32'(item_i.corner_c_index) < VERTEX_COUNT;
  end

  // Classify the item, drop unused modes
  always_comb begin
    cmd_o.idx_a = item_i.vertex_index;
    cmd_o.idx_b = item_i.corner_b_index;
    cmd_o.idx_c = item_i.corner_c_index;
    cmd_o.pos_x = $unsigned(item_i.pos_x);
    cmd_o.pos_y = $unsigned(item_i.pos_y);
    cmd_o.pos_z = $unsigned(item_i.pos_z);
    push_o      = start_i && !busy_o;
    unique case (item_i.mode)
      MODE_LOAD: cmd_o.kind = a_ok ? CMD_LOAD : CMD_ERR;
      MODE_TRI:  cmd_o.kind = (a_ok && b_ok && c_ok) ? CMD_TRI : CMD_ERR;
      MODE_READ: cmd_o.kind = a_ok ? CMD_READ : CMD_ERR;
      default: begin
        cmd_o.kind = CMD_LOAD;
        push_o     = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/vng_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vng_queue: command queue
// Two-entry FIFO between the intake and the execution sequencer.
// ----------------------------------------------------------------------------
module vng_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vng_pkg::cmd_t data_i,
  input  logic          pop_i,
  output vng_pkg::cmd_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import vng_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

@@ rtl/core/vng_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vng_norm: normalization unit
// Scales an accumulated vector, takes the length by a bit-serial square
// root and divides each component by it, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vng_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [vng_pkg::ACC_W-1:0]  acc_x_i,
  input  logic signed [vng_pkg::ACC_W-1:0]  acc_y_i,
  input  logic signed [vng_pkg::ACC_W-1:0]  acc_z_i,
  output logic                              done_o,
  output vng_pkg::result_t                  result_o
);
  import vng_pkg::*;

  localparam int SW  = 30;  // scaled magnitude width
  localparam int QW  = 15;  // quotient width
  localparam int RW  = 62;  // sum of squares width
  localparam int LW  = 31;  // length width
  localparam int NW  = 45;  // dividend width
  localparam logic [ACC_W-1:0] HI_LIM = ACC_W'(1) << 30;
  localparam logic [ACC_W-1:0] LO_LIM = ACC_W'(1) << 29;

  typedef enum logic [2:0] {
    N_IDLE, N_MAX, N_SCALE, N_SQ, N_SQRT, N_DINIT, N_DIV, N_OUT
  } state_e;

  state_e           state_q;
  logic [ACC_W-1:0] s_q [3];
  logic             neg_q [3];
  logic [ACC_W-1:0] m_q;
  logic [RW-1:0]    rem_q, res_q, bit_q;
  logic [4:0]       cnt_q;
  logic [1:0]       comp_q;
  logic [LW-1:0]    drem_q;
  logic [QW-1:0]    num_q, quo_q;
  logic [QW-1:0]    q_q [3];
  logic             done_q;
  result_t          res_out_q;

  logic [ACC_W-1:0] m_c;
  logic [SW-1:0]    sel_c;
  logic [2*SW-1:0]  sq_c;
  logic [RW-1:0]    trial_c;
  logic             sq_ge_c;
  logic [NW-1:0]    num_c;
  logic [LW:0]      dsh_c;
  logic             d_ge_c;
  logic [LW-1:0]    drem_nx_c;
  logic [FIELD_W-1:0] mag_c [3];

  assign done_o   = done_q;
  assign result_o = res_out_q;

  // Datapath helpers
  always_comb begin
    m_c = s_q[0];
    if (s_q[1] > m_c) m_c = s_q[1];
    if (s_q[2] > m_c) m_c = s_q[2];
    sel_c     = s_q[comp_q][SW-1:0];
    sq_c      = sel_c * sel_c;
    trial_c   = res_q + bit_q;
    sq_ge_c   = rem_q >= trial_c;
    num_c     = NW'({sel_c, 14'd0}) + NW'(res_q[LW-1:1]);
    dsh_c     = {drem_q, num_q[QW-1]};
    d_ge_c    = dsh_c >= {1'b0, res_q[LW-1:0]};
    drem_nx_c = d_ge_c ? LW'(dsh_c - {1'b0, res_q[LW-1:0]}) : dsh_c[LW-1:0];
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = neg_q[i] ? -FIELD_W'(q_q[i]) : FIELD_W'(q_q[i]);
    end
  end

  // Sequence the normalization
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            neg_q[0] <= acc_x_i[ACC_W-1];
            neg_q[1] <= acc_y_i[ACC_W-1];
            neg_q[2] <= acc_z_i[ACC_W-1];
            s_q[0]   <= acc_x_i[ACC_W-1] ? ACC_W'(-acc_x_i) : ACC_W'(acc_x_i);
            s_q[1]   <= acc_y_i[ACC_W-1] ? ACC_W'(-acc_y_i) : ACC_W'(acc_y_i);
            s_q[2]   <= acc_z_i[ACC_W-1] ? ACC_W'(-acc_z_i) : ACC_W'(acc_z_i);
            state_q  <= N_MAX;
          end
        end
        N_MAX: begin
          if (m_c == '0) begin
            res_out_q <= RES_DEGEN;
            done_q    <= 1'b1;
            state_q   <= N_IDLE;
          end else begin
            m_q     <= m_c;
            state_q <= N_SCALE;
          end
        end
        N_SCALE: begin
          // Shift all three together until the largest is in range
          if (m_q >= HI_LIM) begin
            for (int i = 0; i < 3; i++) s_q[i] <= s_q[i] >> 1;
            m_q <= m_q >> 1;
          end else if (m_q < LO_LIM) begin
            for (int i = 0; i < 3; i++) s_q[i] <= s_q[i] << 1;
            m_q <= m_q << 1;
          end else begin
            comp_q  <= '0;
            rem_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          rem_q <= rem_q + RW'(sq_c);
          if (comp_q == 2'd2) begin
            res_q   <= '0;
            bit_q   <= RW'(1) << 60;
            cnt_q   <= '0;
            state_q <= N_SQRT;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        N_SQRT: begin
          if (sq_ge_c) begin
            rem_q <= rem_q - trial_c;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd30) begin
            comp_q  <= '0;
            state_q <= N_DINIT;
          end
        end
        N_DINIT: begin
          drem_q  <= LW'(num_c[NW-1:QW]);
          num_q   <= num_c[QW-1:0];
          cnt_q   <= '0;
          state_q <= N_DIV;
        end
        N_DIV: begin
          drem_q <= drem_nx_c;
          num_q  <= num_q << 1;
          quo_q  <= {quo_q[QW-2:0], d_ge_c};
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'(QW - 1)) begin
            q_q[comp_q] <= {quo_q[QW-2:0], d_ge_c};
            if (comp_q == 2'd2) begin
              state_q <= N_OUT;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= N_DINIT;
            end
          end
        end
        N_OUT: begin
          res_out_q.normal_x    <= mag_c[0];
          res_out_q.normal_y    <= mag_c[1];
          res_out_q.normal_z    <= mag_c[2];
          res_out_q.degenerate  <= 1'b0;
          res_out_q.index_error <= 1'b0;
          done_q  <= 1'b1;
          state_q <= N_IDLE;
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vng_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vng_back: execution sequencer
// Owns the position and accumulator memories, runs the cross product and
// the read-modify-write of each corner, and drives the normalization unit.
// ----------------------------------------------------------------------------
module vng_back #(
  parameter int VERTEX_COUNT  = vng_pkg::DEF_VERTEX_COUNT,
  parameter int POSITION_BITS = vng_pkg::DEF_POSITION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  vng_pkg::cmd_t    head_i,
  output logic             pop_o,
  output logic             clear_busy_o,
  output logic             done_o,
  output vng_pkg::result_t result_o
);
  import vng_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int P  = POSITION_BITS;
  localparam int DW = P + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_POS_C, B_DIFF, B_MUL, B_CROSS,
    B_ACC_RD, B_ACC_WR, B_NORM_RD, B_NORM_WAIT
  } state_e;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] addr_q [3];
  logic [1:0]    k_q;
  logic          done_q;
  result_t       result_q;

  // Memories
  logic [3*P-1:0]     pos_mem [VERTEX_COUNT];
  logic [3*ACC_W-1:0] acc_mem [VERTEX_COUNT];
  logic [3*P-1:0]     pos_rd0_q, pos_rd1_q;
  logic [3*ACC_W-1:0] acc_rd_q;

  // Cross product pipeline
  logic [3*P-1:0]         pa_q, pb_q;
  logic signed [DW-1:0]   u_q [3], v_q [3];
  logic signed [PW-1:0]   prod_q [6];
  logic signed [ACC_W-1:0] cross_q [3];

  logic [AW-1:0] ha, hb, hc;
  logic [AW-1:0] pos_ra0, pos_ra1, acc_ra, acc_wa;
  logic          pos_we, acc_we;
  logic [3*P-1:0]     pos_wd;
  logic [3*ACC_W-1:0] acc_wd;
  logic signed [P-1:0]  a_c [3], b_c [3], c_c [3];
  logic signed [DW-1:0] u_c [3], v_c [3];
  logic signed [PW-1:0] prod_c [6];
  logic signed [CW-1:0] cr_c [3];

  logic          norm_start, norm_done;
  result_t       norm_res;

  assign ha = AW'(head_i.idx_a);
  assign hb = AW'(head_i.idx_b);
  assign hc = AW'(head_i.idx_c);

  assign pop_o        = (state_q == B_IDLE) && !empty_i;
  assign clear_busy_o = state_q == B_CLEAR;
  assign done_o       = done_q;
  assign result_o     = result_q;
  assign norm_start   = state_q == B_NORM_RD;

  // Memory address and write selection
  always_comb begin
    pos_ra0 = (state_q == B_IDLE) ? ha : addr_q[2];
    pos_ra1 = hb;
    pos_we  = pop_o && (head_i.kind == CMD_LOAD);
    pos_wd  = {P'(head_i.pos_z), P'(head_i.pos_y), P'(head_i.pos_x)};
    acc_ra  = (state_q == B_IDLE) ? ha : addr_q[k_q];
    acc_we  = 1'b0;
    acc_wa  = addr_q[k_q];
    acc_wd  = '0;
    priority if (state_q == B_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = clr_q;
    end else if (pos_we) begin
      acc_we = 1'b1;
      acc_wa = ha;
    end else if (state_q == B_ACC_WR) begin
      acc_we = 1'b1;
      acc_wd = {sat_add(acc_rd_q[2*ACC_W +: ACC_W], cross_q[2]),
                sat_add(acc_rd_q[ACC_W +: ACC_W], cross_q[1]),
                sat_add(acc_rd_q[0 +: ACC_W], cross_q[0])};
    end
  end

  // Differences, products and cross terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_c[i] = pa_q[i*P +: P];
      b_c[i] = pb_q[i*P +: P];
      c_c[i] = pos_rd0_q[i*P +: P];
      u_c[i] = DW'(a_c[i]) - DW'(c_c[i]);
      v_c[i] = DW'(a_c[i]) - DW'(b_c[i]);
    end
    prod_c[0] = PW'(u_q[1]) * PW'(v_q[2]);
    prod_c[1] = PW'(u_q[2]) * PW'(v_q[1]);
    prod_c[2] = PW'(u_q[2]) * PW'(v_q[0]);
    prod_c[3] = PW'(u_q[0]) * PW'(v_q[2]);
    prod_c[4] = PW'(u_q[0]) * PW'(v_q[1]);
    prod_c[5] = PW'(u_q[1]) * PW'(v_q[0]);
    for (int i = 0; i < 3; i++) begin
      cr_c[i] = CW'(prod_q[2*i]) - CW'(prod_q[2*i+1]);
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[AW'(ha)] <= pos_wd;
    pos_rd0_q <= pos_mem[pos_ra0];
    pos_rd1_q <= pos_mem[pos_ra1];
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd_q <= acc_mem[acc_ra];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == B_POS_C) begin
      pa_q <= pos_rd0_q;
      pb_q <= pos_rd1_q;
    end
    if (state_q == B_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= u_c[i];
        v_q[i] <= v_c[i];
      end
    end
    if (state_q == B_MUL) begin
      for (int i = 0; i < 6; i++) prod_q[i] <= prod_c[i];
    end
    if (state_q == B_CROSS) begin
      for (int i = 0; i < 3; i++) cross_q[i] <= ACC_W'(cr_c[i]);
    end
  end

  // Sequence commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(VERTEX_COUNT - 1)) state_q <= B_IDLE;
        end
        B_IDLE: begin
          if (pop_o) begin
            addr_q[0] <= ha;
            addr_q[1] <= hb;
            addr_q[2] <= hc;
            k_q       <= '0;
            unique case (head_i.kind)
              CMD_LOAD: state_q <= B_IDLE;
              CMD_TRI:  state_q <= B_POS_C;
              CMD_READ: state_q <= B_NORM_RD;
              CMD_ERR: begin
                result_q <= RES_INDEX_ERR;
                done_q   <= 1'b1;
              end
              default: state_q <= B_IDLE;
            endcase
          end
        end
        B_POS_C:  state_q <= B_DIFF;
        B_DIFF:   state_q <= B_MUL;
        B_MUL:    state_q <= B_CROSS;
        B_CROSS:  state_q <= B_ACC_RD;
        B_ACC_RD: state_q <= B_ACC_WR;
        B_ACC_WR: begin
          if (k_q == 2'd2) begin
            state_q <= B_IDLE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= B_ACC_RD;
          end
        end
        B_NORM_RD: state_q <= B_NORM_WAIT;
        B_NORM_WAIT: begin
          if (norm_done) begin
            result_q <= norm_res;
            done_q   <= 1'b1;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  vng_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (norm_start),
    .acc_x_i  (acc_rd_q[0 +: ACC_W]),
    .acc_y_i  (acc_rd_q[ACC_W +: ACC_W]),
    .acc_z_i  (acc_rd_q[2*ACC_W +: ACC_W]),
    .done_o   (norm_done),
    .result_o (norm_res)
  );

endmodule

`default_nettype wire

@@ rtl/core/vertex_normal_generator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_generator_core: smooth area-weighted vertex normals
// Loads vertex positions, accumulates triangle face normals per vertex
// and returns unit normals in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item_i and raise start; the item is taken at an edge where busy
//   is low. Items pass a two-entry queue to the execution sequencer, so a
//   few items can be posted while one is still working.
//   Each result is shown on result_o for one cycle with done_o high; the
//   receiver must take it then. Load and triangle items give no result
//   unless an index is out of range, which gives an error result.
// Steps per item in the sequencer:
//   load is done on the pop; triangle reads two positions, then the third,
//   runs the cross product stages and three accumulator read-modify-writes;
//   error registers its result for output; read takes scale steps (1 to 30),
//   31 square root steps and 48 divide steps.
// Reset:
//   After reset the accumulator memory is swept to zero, one entry a
//   cycle, over all VERTEX_COUNT entries; busy stays high during the sweep.
// ----------------------------------------------------------------------------
module vertex_normal_generator_core #(
  parameter int VERTEX_COUNT  = vng_pkg::DEF_VERTEX_COUNT,
  parameter int POSITION_BITS = vng_pkg::DEF_POSITION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vng_pkg::item_t   item_i,
  output logic             done_o,
  output vng_pkg::result_t result_o
);
  import vng_pkg::*;

  logic push, pop, queue_full, queue_empty, clear_busy;
  cmd_t cmd, head;

  vng_front #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_front (
    .start_i      (start),
    .busy_o       (busy),
    .item_i       (item_i),
    .queue_full_i (queue_full),
    .clear_busy_i (clear_busy),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  vng_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  vng_back #(
    .VERTEX_COUNT  (VERTEX_COUNT),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (queue_empty),
    .head_i       (head),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .done_o       (done_o),
    .result_o     (result_o)
  );

  // No result while the accumulators are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni) clear_busy |-> !done_o)
    else $error("result during clearing sweep");

  // A result is never both degenerate and an index error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.degenerate && result_o.index_error))
    else $error("degenerate and index error together");

  // A degenerate result carries a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.degenerate) |->
      (result_o.normal_x == '0 && result_o.normal_y == '0 && result_o.normal_z == '0))
    else $error("degenerate result with nonzero normal");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !queue_full)
    else $error("push into full queue");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vertex_normal_generator_core
// Loads mesh positions, accumulates random triangles and reads back unit
// normals, predicting every result in-bench and comparing field by field.
// ----------------------------------------------------------------------------
module tb;
  import vng_pkg::*;

  localparam int NVERT      = 1024;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [47:0] ACC_HI = 48'h7FFF_FFFF_FFFF;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  vertex_normal_generator_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Mesh state mirror
  logic signed [15:0] mesh_pos [NVERT][3];
  bit                 pos_loaded [NVERT];
  logic signed [47:0] normal_sum [NVERT][3];

  item_t   pending_items [$];
  result_t normals_due [$];
  int      mismatch_count;
  int      idle_cycles;
  bit      stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating 48-bit add
  function automatic logic signed [47:0] sum_sat(logic signed [47:0] a,
                                                 logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'(signed'(ACC_HI))) return signed'(ACC_HI);
    if (s < -49'(signed'(ACC_HI)) - 49'sd1) return signed'(~ACC_HI);
    return s[47:0];
  endfunction

  // Integer square root, bit by bit
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to [2^29, 2^30), divide by the length, restore signs
  function automatic result_t unit_normal(int unsigned v);
    result_t         r;
    longint unsigned s [3];
    longint unsigned m, len, q;
    r = '0;
    for (int i = 0; i < 3; i++)
      s[i] = normal_sum[v][i] < 0 ? 64'(-65'(normal_sum[v][i])) : 64'(normal_sum[v][i]);
    m = s[0];
    if (s[1] > m) m = s[1];
    if (s[2] > m) m = s[2];
    if (m == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) s[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) s[i] <<= 1;
      m <<= 1;
    end
    len = root64(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]);
    for (int i = 0; i < 3; i++) begin
      q = (s[i] * 64'd16384 + (len >> 1)) / len;
      if (normal_sum[v][i] < 0) q = -q;
      case (i)
        0: r.normal_x = q[15:0];
        1: r.normal_y = q[15:0];
        default: r.normal_z = q[15:0];
      endcase
    end
    return r;
  endfunction

  // Update the mirror for one accepted item and queue any result
  task automatic predict_item(item_t it);
    result_t            err;
    logic signed [63:0] u [3];
    logic signed [63:0] w [3];
    logic signed [63:0] c [3];
    int unsigned        idx [3];
    err = '0;
    err.index_error = 1'b1;
    idx[0] = 32'(it.vertex_index);
    idx[1] = 32'(it.corner_b_index);
    idx[2] = 32'(it.corner_c_index);
    case (it.mode)
      MODE_LOAD: begin
        if (idx[0] >= NVERT) begin
          normals_due.push_back(err);
        end else begin
          for (int i = 0; i < 3; i++) normal_sum[idx[0]][i] = '0;
          mesh_pos[idx[0]][0] = it.pos_x;
          mesh_pos[idx[0]][1] = it.pos_y;
          mesh_pos[idx[0]][2] = it.pos_z;
        end
      end
      MODE_TRI: begin
        if (idx[0] >= NVERT || idx[1] >= NVERT || idx[2] >= NVERT) begin
          normals_due.push_back(err);
        end else begin
          for (int i = 0; i < 3; i++) begin
            u[i] = 64'(mesh_pos[idx[0]][i]) - 64'(mesh_pos[idx[2]][i]);
            w[i] = 64'(mesh_pos[idx[0]][i]) - 64'(mesh_pos[idx[1]][i]);
          end
          c[0] = u[1] * w[2] - u[2] * w[1];
          c[1] = u[2] * w[0] - u[0] * w[2];
          c[2] = u[0] * w[1] - u[1] * w[0];
          for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
              normal_sum[idx[k]][i] = sum_sat(normal_sum[idx[k]][i], c[i][47:0]);
        end
      end
      MODE_READ: begin
        if (idx[0] >= NVERT) normals_due.push_back(err);
        else normals_due.push_back(unit_normal(idx[0]));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic item_t rand_item(logic [1:0] m, int a, int b, int c);
    item_t it;
    it.mode           = m;
    it.vertex_index   = IDX_W'(a);
    it.corner_b_index = IDX_W'(b);
    it.corner_c_index = IDX_W'(c);
    it.pos_x          = FIELD_W'($urandom);
    it.pos_y          = FIELD_W'($urandom);
    it.pos_z          = FIELD_W'($urandom);
    return it;
  endfunction

  // Pick a loaded vertex from the first span vertices
  function automatic int loaded_vertex(int span);
    int v;
    v = $urandom_range(span - 1);
    while (!pos_loaded[v]) v = $urandom_range(span - 1);
    return v;
  endfunction

  // Stimulus: directed corners, then mesh building and reads
  initial begin
    item_t it;
    int    span, a;
    for (int v = 0; v < NVERT; v++)
      for (int i = 0; i < 3; i++) normal_sum[v][i] = '0;
    for (int i = 0; i < 8; i++) begin
      it = rand_item(MODE_LOAD, i, 0, 0);
      case (i)
        0: begin it.pos_x = 16'sh7FFF; it.pos_y = 16'sh8000; it.pos_z = 16'sh7FFF; end
        1: begin it.pos_x = 16'sh8000; it.pos_y = 16'sh7FFF; it.pos_z = 16'sh8000; end
        2: begin it.pos_x = 16'sh8000; it.pos_y = 16'sh8000; it.pos_z = 16'sh7FFF; end
        3: begin it.pos_x = 16'sh0; it.pos_y = 16'sh0; it.pos_z = 16'sh0; end
        default: ;
      endcase
      pending_items.push_back(it);
      pos_loaded[i] = 1'b1;
    end
    it = rand_item(MODE_LOAD, 1023, 0, 0);
    pending_items.push_back(it);
    pos_loaded[1023] = 1'b1;
    pending_items.push_back(rand_item(MODE_READ, 3, 0, 0));   // zero sum
    pending_items.push_back(rand_item(MODE_TRI, 0, 1, 2));
    pending_items.push_back(rand_item(MODE_TRI, 0, 1, 2));    // same triangle again
    pending_items.push_back(rand_item(MODE_TRI, 1023, 4, 5));
    pending_items.push_back(rand_item(MODE_TRI, 4, 4, 6));    // repeated corners
    pending_items.push_back(rand_item(2'd3, 1023, 1023, 1023));
    pending_items.push_back(rand_item(MODE_READ, 0, 0, 0));
    pending_items.push_back(rand_item(MODE_READ, 1, 0, 0));
    pending_items.push_back(rand_item(MODE_READ, 1023, 0, 0));
    pending_items.push_back(rand_item(MODE_READ, 4, 0, 0));
    pending_items.push_back(rand_item(MODE_READ, 5, 0, 0));
    // Random mesh traffic, mostly on a small set of loaded vertices
    for (int n = 0; n < 1600; n++) begin
      span = ($urandom_range(9) == 0) ? NVERT : 24;
      case ($urandom_range(9))
        0, 1: begin
          a = $urandom_range(span - 1);
          pending_items.push_back(rand_item(MODE_LOAD, a, $urandom, $urandom));
          pos_loaded[a] = 1'b1;
        end
        2, 3, 4, 5, 6:
          pending_items.push_back(rand_item(MODE_TRI, loaded_vertex(span),
                                            loaded_vertex(span), loaded_vertex(span)));
        7, 8: pending_items.push_back(rand_item(MODE_READ, $urandom_range(span - 1),
                                                $urandom, $urandom));
        default: pending_items.push_back(rand_item(2'd3, $urandom, $urandom, $urandom));
      endcase
    end
  end

  // Driver: present items at the falling edge with random gaps
  initial begin
    int gap;
    start  = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_items.size() != 0) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40) :
            (($urandom_range(2) == 0) ? 0 : $urandom_range(3));
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      start  <= 1'b1;
      item_i <= pending_items[0];
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      predict_item(pending_items.pop_front());
      @(negedge clk_i);
    end
    start <= 1'b0;
    stim_done = 1'b1;
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (normals_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = normals_due.pop_front();
        if (result_o.normal_x !== want.normal_x)
          report_mismatch("normal_x", result_o.normal_x, want.normal_x);
        if (result_o.normal_y !== want.normal_y)
          report_mismatch("normal_y", result_o.normal_y, want.normal_y);
        if (result_o.normal_z !== want.normal_z)
          report_mismatch("normal_z", result_o.normal_z, want.normal_z);
        if (result_o.degenerate !== want.degenerate)
          report_mismatch("degenerate", result_o.degenerate, want.degenerate);
        if (result_o.index_error !== want.index_error)
          report_mismatch("index_error", result_o.index_error, want.index_error);
      end
    end
  end

  // Watchdog: count cycles with no item or result taken
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Drain and finish
  initial begin
    wait (stim_done);
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && normals_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/vng_pkg.sv
rtl/core/vng_front.sv
rtl/core/vng_queue.sv
rtl/core/vng_norm.sv
rtl/core/vng_back.sv
rtl/core/vertex_normal_generator_core.sv
tb/tb.sv
